// File: hdl/wsfd_pkg.sv
// ----------------------------------------------------------------------------
// wsfd_pkg: shared types and constants for the websocket frame deframer
// holds the parse phase encoding, header constants and the result word type
// ----------------------------------------------------------------------------
package wsfd_pkg;

   // parse phases, one-hot
   typedef enum logic [4:0] {
      PH_HDR0    = 5'b00001,
      PH_HDR1    = 5'b00010,
      PH_EXTLEN  = 5'b00100,
      PH_MASKKEY = 5'b01000,
      PH_PAYLOAD = 5'b10000
   } phase_type;

   // 7-bit length codes that select the extended length forms
   localparam logic [6:0] LEN_CODE16 = 7'd126;
   localparam logic [6:0] LEN_CODE64 = 7'd127;

   // extended length / mask key byte counts, minus one
   localparam logic [2:0] EXT16_LAST  = 3'd1;
   localparam logic [2:0] EXT64_LAST  = 3'd7;
   localparam logic [2:0] MASKKEY_LAST = 3'd3;

   // data opcodes that can end a complete message
   localparam logic [3:0] OP_TEXT   = 4'd1;
   localparam logic [3:0] OP_BINARY = 4'd2;

   // one result word
   typedef struct packed {
      logic [7:0] payload_byte;
      logic       payload_valid;
      logic       end_of_frame;
      logic       complete_message;
      logic [3:0] frame_opcode;
   } rsp_type;

endpackage

// File: hdl/wsfd_req_if.sv
// ----------------------------------------------------------------------------
// wsfd_req_if: raw byte stream channel
// valid/ready handshake carrying one received stream byte per word
// ----------------------------------------------------------------------------
interface wsfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

// File: hdl/wsfd_rsp_if.sv
// ----------------------------------------------------------------------------
// wsfd_rsp_if: deframed payload channel
// valid/ready handshake carrying one payload byte or end marker per word
// ----------------------------------------------------------------------------
interface wsfd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] payload_byte;
   logic       payload_valid;
   logic       end_of_frame;
   logic       complete_message;
   logic [3:0] frame_opcode;

   modport source (output valid, output payload_byte, output payload_valid,
                   output end_of_frame, output complete_message,
                   output frame_opcode, input ready);
   modport sink   (input valid, input payload_byte, input payload_valid,
                   input end_of_frame, input complete_message,
                   input frame_opcode, output ready);
endinterface

// File: hdl/wsfd_parser.sv
// ----------------------------------------------------------------------------
// wsfd_parser: per-byte frame header parser and payload unmasker
// updates the parse state on every accepted byte and forms at most one result
// ----------------------------------------------------------------------------
module wsfd_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       in_byte,
   output logic             res_valid,
   output wsfd_pkg::rsp_type res
);
   import wsfd_pkg::*;

   phase_type   phase_ff,  phase_in;
   logic        fin_ff,    fin_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic        masked_ff, masked_in;
   logic [2:0]  count_ff,  count_in;
   logic [63:0] rem_ff,    rem_in;
   logic [31:0] key_ff,    key_in;
   logic [1:0]  idx_ff,    idx_in;

   always_comb begin
      logic        len_known;
      logic        hdr_done;
      logic [63:0] len_val;
      logic [6:0]  code;
      logic [7:0]  kb;
      logic        last;

      phase_in  = phase_ff;
      fin_in    = fin_ff;
      opcode_in = opcode_ff;
      masked_in = masked_ff;
      count_in  = count_ff;
      rem_in    = rem_ff;
      key_in    = key_ff;
      idx_in    = idx_ff;
      len_known = 1'b0;
      hdr_done  = 1'b0;
      len_val   = rem_ff;
      code      = in_byte[6:0];
      kb        = 8'h00;
      last      = 1'b0;
      res_valid = 1'b0;
      res       = '0;
      res.frame_opcode = opcode_ff;

      case (phase_ff)
         PH_HDR1: begin
            masked_in = in_byte[7];
            if (code == LEN_CODE16 || code == LEN_CODE64) begin
               rem_in   = '0;
               count_in = (code == LEN_CODE16) ? EXT16_LAST : EXT64_LAST;
               phase_in = PH_EXTLEN;
            end else begin
               len_val   = {57'd0, code};
               len_known = 1'b1;
            end
         end
         PH_EXTLEN: begin
            len_val = {rem_ff[55:0], in_byte};
            if (count_ff == 3'd0) begin
               len_known = 1'b1;
            end else begin
               rem_in   = len_val;
               count_in = count_ff - 3'd1;
            end
         end
         PH_MASKKEY: begin
            key_in = {key_ff[23:0], in_byte};
            if (count_ff == 3'd0) begin
               hdr_done = 1'b1;
            end else begin
               count_in = count_ff - 3'd1;
            end
         end
         PH_PAYLOAD: begin
            if (masked_ff) begin
               kb = key_ff[{~idx_ff, 3'b000} +: 8];
            end
            idx_in = idx_ff + 2'd1;
            rem_in = rem_ff - 64'd1;
            last   = (rem_ff == 64'd1);
            if (last) begin
               phase_in = PH_HDR0;
            end
            res_valid            = 1'b1;
            res.payload_byte     = in_byte ^ kb;
            res.payload_valid    = 1'b1;
            res.end_of_frame     = last;
            res.complete_message = last && fin_ff &&
                                   (opcode_ff == OP_TEXT || opcode_ff == OP_BINARY);
         end
         default: begin
            // first header byte, also any stray phase code
            fin_in    = in_byte[7];
            opcode_in = in_byte[3:0];
            phase_in  = PH_HDR1;
         end
      endcase

      // length known: mask key next, or header finished
      if (len_known) begin
         rem_in = len_val;
         if (masked_in) begin
            phase_in = PH_MASKKEY;
            count_in = MASKKEY_LAST;
            key_in   = '0;
         end else begin
            hdr_done = 1'b1;
         end
      end

      // header finished: payload follows, or the frame is empty
      if (hdr_done) begin
         idx_in = 2'd0;
         if (len_val == 64'd0) begin
            phase_in             = PH_HDR0;
            res_valid            = 1'b1;
            res.end_of_frame     = 1'b1;
            res.complete_message = fin_ff &&
                                   (opcode_ff == OP_TEXT || opcode_ff == OP_BINARY);
         end else begin
            phase_in = PH_PAYLOAD;
         end
      end

      if (!accept) begin
         res_valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HDR0;
         fin_ff    <= 1'b0;
         opcode_ff <= 4'd0;
         masked_ff <= 1'b0;
         count_ff  <= 3'd0;
         rem_ff    <= '0;
         key_ff    <= '0;
         idx_ff    <= 2'd0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         fin_ff    <= fin_in;
         opcode_ff <= opcode_in;
         masked_ff <= masked_in;
         count_ff  <= count_in;
         rem_ff    <= rem_in;
         key_ff    <= key_in;
         idx_ff    <= idx_in;
      end
   end

   a_empty_is_end: assert property (@(posedge clock) disable iff (reset)
      res_valid && !res.payload_valid |-> res.end_of_frame && res.payload_byte == 8'h00)
      else $error("empty result without end of frame");

   a_complete_at_end: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.complete_message |-> res.end_of_frame)
      else $error("complete message flagged before end of frame");

   a_payload_has_length: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> rem_ff != 64'd0)
      else $error("payload phase with no bytes left");

endmodule

// File: hdl/wsfd_out_buf.sv
// ----------------------------------------------------------------------------
// wsfd_out_buf: result register with one skid entry
// decouples the result channel from the byte input, ready is registered
// ----------------------------------------------------------------------------
module wsfd_out_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  wsfd_pkg::rsp_type push_data,
   output logic              space,
   output logic              out_valid,
   output wsfd_pkg::rsp_type out_data,
   input  logic              out_ready
);
   import wsfd_pkg::*;

   logic    out_valid_ff,  out_valid_in;
   rsp_type out_data_ff,   out_data_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_data_ff,  skid_data_in;
   logic    take;

   assign take = out_valid_ff && out_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || take) begin
            out_valid_in = 1'b1;
            out_data_in  = push_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = push_data;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign space     = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held with empty output register");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !skid_valid_ff)
      else $error("result pushed while skid entry is occupied");

   a_stall_fills_skid: assert property (@(posedge clock) disable iff (reset)
      push && out_valid_ff && !out_ready |=> skid_valid_ff)
      else $error("stalled result not captured in skid entry");

endmodule

// File: hdl/websocket_frame_deframer_top.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer_top: byte-serial websocket frame deframer
// req_chan takes the raw frame stream, one byte per word, frames back to back.
// the parser reads the fin bit and opcode, the 7-bit length with its 16-bit or
// 64-bit extended forms, and the optional 4-byte mask key; header bytes give
// no word on rsp_chan. each payload byte leaves rsp_chan unmasked, the last
// one flagged end_of_frame with complete_message for a final text or binary
// frame; an empty frame gives a single end word with payload_valid low.
// a result word is registered in the result register, or in the skid entry
// while the receiver stalls. throughput: one byte per cycle while the skid entry is
// free; the parse step between the parser state registers and the result register is combinational.
// reset: parser waits for a first header byte, result buffer is empty.
// receiver stall: the result register plus one skid entry absorb the stall;
// req_chan.ready drops only once the skid entry holds a word, so header bytes
// and one more payload byte are still taken while a result waits.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_top (
   input  logic       clock,
   input  logic       reset,
   wsfd_req_if.sink   req_chan,
   wsfd_rsp_if.source rsp_chan
);
   import wsfd_pkg::*;

   logic    accept;
   logic    res_valid;
   rsp_type res;
   logic    space;
   logic    out_valid;
   rsp_type out_data;

   // byte taken when the buffer has room for a possible result
   assign req_chan.ready = space;
   assign accept         = req_chan.valid && space;

   // header parse and unmask, one byte per cycle while the buffer has room
   wsfd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .in_byte   (req_chan.in_byte),
      .res_valid (res_valid),
      .res       (res)
   );

   // result register and skid entry
   wsfd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .space     (space),
      .out_valid (out_valid),
      .out_data  (out_data),
      .out_ready (rsp_chan.ready)
   );

   // result channel payload
   assign rsp_chan.valid            = out_valid;
   assign rsp_chan.payload_byte     = out_data.payload_byte;
   assign rsp_chan.payload_valid    = out_data.payload_valid;
   assign rsp_chan.end_of_frame     = out_data.end_of_frame;
   assign rsp_chan.complete_message = out_data.complete_message;
   assign rsp_chan.frame_opcode     = out_data.frame_opcode;

endmodule
